[rtl/core/sot_pkg.sv]
package sot_pkg;

  // lexer modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_SLASH  = 4'd1;
  localparam logic [3:0] M_LCOMM  = 4'd2;
  localparam logic [3:0] M_BCOMM  = 4'd3;
  localparam logic [3:0] M_BSTAR  = 4'd4;
  localparam logic [3:0] M_QUOTED = 4'd5;
  localparam logic [3:0] M_WORD   = 4'd6;
  localparam logic [3:0] M_OP     = 4'd7;

  // token types
  localparam logic [3:0] T_GEN     = 4'd0;
  localparam logic [3:0] T_WORD    = 4'd1;
  localparam logic [3:0] T_QUOTED  = 4'd2;
  localparam logic [3:0] T_EOF     = 4'd3;
  localparam logic [3:0] T_NEWLINE = 4'd4;
  localparam logic [3:0] T_STAR    = 4'd5;
  localparam logic [3:0] T_OPEN    = 4'd6;
  localparam logic [3:0] T_CLOSE   = 4'd7;
  localparam logic [3:0] T_NEQ     = 4'd8;
  localparam logic [3:0] T_EQ      = 4'd9;
  localparam logic [3:0] T_GT      = 4'd10;
  localparam logic [3:0] T_GTE     = 4'd11;
  localparam logic [3:0] T_LT      = 4'd12;
  localparam logic [3:0] T_LTE     = 4'd13;
  localparam logic [3:0] T_OR      = 4'd14;
  localparam logic [3:0] T_AND     = 4'd15;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic [7:0]  tbyte;
    logic        bvalid;
    logic        last;
    logic [3:0]  ttype;
    logic [31:0] line;
  } sot_result_t;

  function automatic logic is_sep(logic [7:0] c);
    logic s;
    s = (c == CH_NUL) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
        (c >= CH_SP && c <= CH_COMMA) || (c >= CH_COLON && c <= CH_AT) ||
        (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_CARET) ||
        (c == CH_BTICK) || (c >= CH_LBRACE && c <= CH_DEL);
    return s;
  endfunction

endpackage

[rtl/core/script_operator_tokenizer.sv]
// Channel   Signals                                       Direction  Transfer when
// -------   --------------------------------------------  ---------  ------------------------
// text      text_valid, text_stall, text_byte             in         text_valid & !text_stall
// token     token_valid, token_stall, token_byte,         out        token_valid & !token_stall
//           byte_valid, token_last, token_type, token_line
// cfg       cfg_we, cfg_wdata (allow_line_breaks)         in         cfg_we
//
// One text byte per cycle while text_stall is low. Each transfer is lexed in
// the same cycle against the state registers and its 0..2 results are
// registered into a 4-entry result queue that feeds the token channel. The
// queue drains one result per cycle while token_stall is low.
// text_stall is high while the queue has fewer than two free entries.
// rst is synchronous: state returns to between-tokens, line 1, queue empty,
// allow_line_breaks = 1.
module script_operator_tokenizer #(
  parameter int MAX_TOKEN_LEN = 1024,
  parameter int LINE_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [7:0]  token_byte,
  output logic        byte_valid,
  output logic        token_last,
  output logic [3:0]  token_type,
  output logic [31:0] token_line
);
  import sot_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN);
  localparam logic [LEN_W-1:0] TOK_LIMIT = LEN_W'(MAX_TOKEN_LEN - 1);
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

  typedef struct packed {
    logic [3:0]           mode;
    logic [7:0]           pend;
    logic [LEN_W-1:0]     len;
    logic [LINE_BITS-1:0] line;
    logic [LINE_BITS-1:0] start;
    logic                 cr;
  } lex_state_t;

  typedef struct packed {
    lex_state_t  st;
    logic        emit;
    sot_result_t res;
  } btw_t;

  function automatic sot_result_t mk_res(logic [7:0] b, logic v, logic l,
                                         logic [3:0] t, logic [LINE_BITS-1:0] ln);
    sot_result_t r;
    r.tbyte  = b;
    r.bvalid = v;
    r.last   = l;
    r.ttype  = l ? t : T_GEN;
    r.line   = l ? 32'(ln) : 32'd0;
    return r;
  endfunction

  // saturating line increment
  function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] ln);
    return (ln == '1) ? ln : ln + LINE_ONE;
  endfunction

  // Handling of a byte between tokens. Also used when a token is closed by the
  // byte that follows it.
  function automatic btw_t between_f(logic [7:0] c, logic merge, logic allow,
                                     lex_state_t s);
    btw_t       b;
    logic [3:0] ty;
    logic       single;
    b         = '0;
    b.st      = s;
    b.st.mode = M_IDLE;
    ty        = T_GEN;
    single    = 1'b0;
    unique case (c)
      CH_NUL: begin
        b.emit = 1'b1;
        b.res  = mk_res(8'd0, 1'b0, 1'b1, T_EOF, s.line);
        b.st.pend  = 8'd0;
        b.st.len   = '0;
        b.st.line  = LINE_ONE;
        b.st.start = LINE_ONE;
        b.st.cr    = 1'b0;
      end
      CH_SP, CH_TAB: ;
      CH_LF, CH_CR: begin
        if (!merge) begin
          b.st.line = line_inc(s.line);
          if (c == CH_CR) b.st.cr = 1'b1;
          if (!allow) begin
            b.emit = 1'b1;
            b.res  = mk_res(8'd0, 1'b0, 1'b1, T_NEWLINE, line_inc(s.line));
          end
        end
      end
      CH_SLASH: begin
        b.st.mode  = M_SLASH;
        b.st.start = s.line;
        b.st.len   = '0;
      end
      CH_QUOTE: begin
        b.st.mode  = M_QUOTED;
        b.st.start = s.line;
        b.st.len   = '0;
      end
      CH_STAR: begin single = 1'b1; ty = T_STAR; end
      CH_LPAR: begin single = 1'b1; ty = T_OPEN; end
      CH_RPAR: begin single = 1'b1; ty = T_CLOSE; end
      CH_PLUS, CH_BTICK, CH_TILDE, CH_LBRACE, CH_RBRACE, CH_LBRK, CH_RBRK,
      CH_QMARK, CH_COMMA, CH_COLON, CH_SEMI, CH_PCT, CH_CARET: single = 1'b1;
      CH_BANG, CH_EQ, CH_GT, CH_LT, CH_BAR, CH_AMP: begin
        b.st.mode  = M_OP;
        b.st.start = s.line;
        b.st.pend  = c;
        b.st.len   = LEN_W'(1);
        b.emit     = 1'b1;
        b.res      = mk_res(c, 1'b1, 1'b0, T_GEN, s.line);
      end
      default: begin
        b.st.mode  = M_WORD;
        b.st.start = s.line;
        b.st.len   = LEN_W'(1);
        b.emit     = 1'b1;
        b.res      = mk_res(c, 1'b1, 1'b0, T_GEN, s.line);
      end
    endcase
    if (single) begin
      b.st.start = s.line;
      b.emit     = 1'b1;
      b.res      = mk_res(c, 1'b1, 1'b1, ty, s.line);
    end
    return b;
  endfunction

  // state
  logic        allow_line_breaks;
  lex_state_t  st, st_next;

  // result queue
  sot_result_t          q [QDEPTH];
  logic [QPTR_W-1:0]    wp, rp;
  logic [QCNT_W-1:0]    count, count_next;

  // step logic
  lex_state_t  s0;
  btw_t        b;
  logic        use_b;
  logic        e0;
  sot_result_t r0;
  logic        merge, nl;
  logic [7:0]  c;
  logic [7:0]  second;
  logic [3:0]  pair_t, single_t;
  logic [1:0]  n_res;
  sot_result_t slot0, slot1;
  logic        in_xfer, out_xfer;

  assign in_xfer  = text_valid && !text_stall;
  assign out_xfer = token_valid && !token_stall;

  always_comb begin
    c      = text_byte;
    merge  = st.cr && (c == CH_LF);
    nl     = (c == CH_LF) || (c == CH_CR);
    s0     = st;
    s0.cr  = 1'b0;
    b      = between_f(c, merge, allow_line_breaks, s0);
    use_b  = 1'b0;
    e0     = 1'b0;
    r0     = '0;
    st_next = s0;
    second   = CH_EQ;
    pair_t   = T_AND;
    single_t = T_GEN;

    unique case (st.mode)
      M_SLASH: begin
        if (c == CH_SLASH) st_next.mode = M_LCOMM;
        else if (c == CH_STAR) st_next.mode = M_BCOMM;
        else begin
          // lone slash: generic token, then lex this byte afresh
          e0    = 1'b1;
          r0    = mk_res(CH_SLASH, 1'b1, 1'b1, T_GEN, st.start);
          use_b = 1'b1;
        end
      end
      M_LCOMM: begin
        if (c == CH_NUL || nl) use_b = 1'b1;
      end
      M_BCOMM, M_BSTAR: begin
        if (c == CH_NUL) use_b = 1'b1;
        else if (nl) begin
          if (!merge) begin
            st_next.line = line_inc(st.line);
            if (c == CH_CR) st_next.cr = 1'b1;
          end
          st_next.mode = M_BCOMM;
        end else if (c == CH_STAR) st_next.mode = M_BSTAR;
        else if (c == CH_SLASH && st.mode == M_BSTAR) st_next.mode = M_IDLE;
        else st_next.mode = M_BCOMM;
      end
      M_QUOTED: begin
        if (c == CH_NUL || c == CH_QUOTE) begin
          e0           = 1'b1;
          r0           = mk_res(8'd0, 1'b0, 1'b1, T_QUOTED, st.start);
          st_next.mode = M_IDLE;
          if (c == CH_NUL) use_b = 1'b1;
        end else begin
          // line breaks inside a string still count
          if (nl && !merge) begin
            st_next.line = line_inc(st.line);
            if (c == CH_CR) st_next.cr = 1'b1;
          end
          if (st.len < TOK_LIMIT) begin
            st_next.len = st.len + LEN_W'(1);
            e0          = 1'b1;
            r0          = mk_res(c, 1'b1, 1'b0, T_GEN, st.start);
          end
        end
      end
      M_WORD: begin
        if (is_sep(c)) begin
          e0    = 1'b1;
          r0    = mk_res(8'd0, 1'b0, 1'b1, T_WORD, st.start);
          use_b = 1'b1;
        end else if (st.len < TOK_LIMIT) begin
          st_next.len = st.len + LEN_W'(1);
          e0          = 1'b1;
          r0          = mk_res(c, 1'b1, 1'b0, T_GEN, st.start);
        end
      end
      M_OP: begin
        second = (st.pend == CH_BAR || st.pend == CH_AMP) ? st.pend : CH_EQ;
        unique case (st.pend)
          CH_BANG: begin pair_t = T_NEQ; single_t = T_GEN; end
          CH_EQ:   begin pair_t = T_EQ;  single_t = T_GEN; end
          CH_GT:   begin pair_t = T_GTE; single_t = T_GT;  end
          CH_LT:   begin pair_t = T_LTE; single_t = T_LT;  end
          CH_BAR:  begin pair_t = T_OR;  single_t = T_GEN; end
          default: begin pair_t = T_AND; single_t = T_GEN; end
        endcase
        st_next.mode = M_IDLE;
        e0           = 1'b1;
        if (c == second) begin
          // second char of the pair is dropped once the token is full
          if (st.len < TOK_LIMIT) r0 = mk_res(c, 1'b1, 1'b1, pair_t, st.start);
          else r0 = mk_res(8'd0, 1'b0, 1'b1, pair_t, st.start);
        end else begin
          r0    = mk_res(8'd0, 1'b0, 1'b1, single_t, st.start);
          use_b = 1'b1;
        end
      end
      default: use_b = 1'b1;
    endcase

    if (use_b) st_next = b.st;

    // pack results toward slot 0
    if (e0) begin
      slot0 = r0;
      slot1 = b.res;
      n_res = (use_b && b.emit) ? 2'd2 : 2'd1;
    end else begin
      slot0 = b.res;
      slot1 = b.res;
      n_res = (use_b && b.emit) ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_line_breaks <= 1'b1;
      st.mode  <= M_IDLE;
      st.pend  <= 8'd0;
      st.len   <= '0;
      st.line  <= LINE_ONE;
      st.start <= LINE_ONE;
      st.cr    <= 1'b0;
    end else begin
      if (cfg_we) allow_line_breaks <= cfg_wdata;
      if (in_xfer) st <= st_next;
    end
  end

  // result queue: up to two writes, one read per cycle
  always_comb begin
    count_next = count;
    if (in_xfer) count_next = count_next + QCNT_W'(n_res);
    if (out_xfer) count_next = count_next - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (in_xfer) wp <= wp + QPTR_W'(n_res);
      if (out_xfer) rp <= rp + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (n_res != 2'd0) q[wp] <= slot0;
      if (n_res == 2'd2) q[wp + QPTR_W'(1)] <= slot1;
    end
  end

  assign text_stall  = (count > QCNT_W'(QDEPTH - 2));
  assign token_valid = (count != '0);
  assign token_byte  = q[rp].tbyte;
  assign byte_valid  = q[rp].bvalid;
  assign token_last  = q[rp].last;
  assign token_type  = q[rp].ttype;
  assign token_line  = q[rp].line;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // a mid-token result always carries a character and no tag
  assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_last |-> byte_valid && token_type == T_GEN && token_line == 32'd0)
    else $error("mid-token result malformed");

  // end markers are always last results
  assert property (@(posedge clk) disable iff (rst)
    token_valid && !byte_valid |-> token_last)
    else $error("end marker without last");

  // after an end of text the lexer is back at line 1 between tokens
  assert property (@(posedge clk) disable iff (rst)
    in_xfer && text_byte == CH_NUL |=> st.mode == M_IDLE && st.line == LINE_ONE)
    else $error("end of text did not restart lexer");

endmodule
